@@ hw/rtl/wind_direction_vector_mean_macros.svh @@
// Assertion macros shared by the wind direction vector mean RTL.
`ifndef WIND_DIRECTION_VECTOR_MEAN_MACROS_SVH
`define WIND_DIRECTION_VECTOR_MEAN_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define WDVM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define WDVM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/wdvm_pkg.sv @@
// Shared types, constants and the trig table builder for the wind direction mean.
package wdvm_pkg;

    // Direction input
    localparam int DIR_BITS = 9;
    localparam logic [DIR_BITS-1:0] DIR_LIMIT = 9'd360;
    localparam int ROM_DEPTH = 360;

    // Result count field width
    localparam int OUT_COUNT_BITS = 16;

    // Angle format: signed Q9.24 degrees
    localparam int DEG_FRAC = 24;
    localparam int Z_BITS = 34;
    localparam int STEP_TABLE_LEN = 24;
    localparam int STEP_IDX_BITS = 5;

    typedef logic signed [Z_BITS-1:0] angle_t;

    // atan(2^-i) in degrees, Q.24
    localparam angle_t STEP_ANGLE [STEP_TABLE_LEN] = '{
        34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
        34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
        34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
        34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
        34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
        34'sd917,       34'sd458,       34'sd229,       34'sd115
    };

    localparam angle_t FULL_TURN   = angle_t'(64'd360 << DEG_FRAC);
    localparam angle_t HALF_TURN   = angle_t'(64'd180 << DEG_FRAC);
    localparam angle_t ANGLE_GUARD = angle_t'(64'd1 << (DEG_FRAC - 7));

    // Trig table storage; entries hold at most the widest supported format.
    localparam int TRIG_MAX_BITS = 24;
    typedef logic signed [TRIG_MAX_BITS-1:0] trig_word_t;
    typedef trig_word_t trig_rom_t [ROM_DEPTH];

    // CORDIC rotation gain start value in Q2.30
    localparam longint GAIN_Q30 = 64'sh26DD3B6A;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                     load_item;
        logic                     accumulate;
        logic                     cordic_init;
        logic                     cordic_step;
        logic [STEP_IDX_BITS-1:0] step_idx;
        logic                     finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mean_trivial;
    } dp_status_t;

    // Builds the cosine or sine table at elaboration. Each entry is a 24-step
    // rotation CORDIC in Q2.30 on the angle folded into -90..90 degrees,
    // then rounded to nearest and saturated to signed Q1.(trig_bits-1).
    function automatic trig_rom_t build_trig_rom(input int trig_bits, input logic want_sine);
        trig_rom_t rom;
        longint    x;
        longint    y;
        longint    z;
        longint    dx;
        longint    dy;
        longint    v;
        longint    r;
        longint    hi;
        longint    lo;
        int        fold;
        int        s;
        int        d;
        int        i;
        logic      flip;
        hi = (longint'(1) <<< (trig_bits - 1)) - 1;
        lo = -(longint'(1) <<< (trig_bits - 1));
        s  = 31 - trig_bits;
        for (d = 0; d < ROM_DEPTH; d++)
        begin
            x    = GAIN_Q30;
            y    = 0;
            flip = 1'b0;
            fold = d;
            // Back half of the circle is turned round by half a turn.
            if (d > 90 && d < 270)
            begin
                fold = d - 180;
                flip = 1'b1;
            end
            else if (d >= 270)
            begin
                fold = d - 360;
            end
            z = longint'(fold) * (longint'(1) <<< DEG_FRAC);
            for (i = 0; i < STEP_TABLE_LEN; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(STEP_ANGLE[i]);
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(STEP_ANGLE[i]);
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            v = want_sine ? y : x;
            r = (v + (longint'(1) <<< (s - 1))) >>> s;
            if (r > hi)
            begin
                r = hi;
            end
            if (r < lo)
            begin
                r = lo;
            end
            rom[d] = trig_word_t'(r);
        end
        return rom;
    endfunction

endpackage

@@ hw/rtl/wdvm_ctrl.sv @@
// Controller state machine sequencing one item through the datapath.
module wdvm_ctrl #(
    parameter int ARCTAN_STEPS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  wdvm_pkg::dp_status_t status,
    output wdvm_pkg::dp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_INIT = 3'd2;
    localparam logic [2:0] S_ITER = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam logic [wdvm_pkg::STEP_IDX_BITS-1:0] LAST_STEP =
        wdvm_pkg::STEP_IDX_BITS'(ARCTAN_STEPS - 1);

    logic [2:0]                          state_reg;
    logic [2:0]                          state_next;
    logic [wdvm_pkg::STEP_IDX_BITS-1:0]  step_reg;
    logic [wdvm_pkg::STEP_IDX_BITS-1:0]  step_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic                                out_free;

    // The result register may be refilled once it is empty or being taken.
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state, step counter and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.step_idx   = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.accumulate = 1'b1;
                state_next     = S_INIT;
            end
            S_INIT:
            begin
                cmd.cordic_init = 1'b1;
                step_next       = '0;
                state_next      = status.mean_trivial ? S_FIN : S_ITER;
            end
            S_ITER:
            begin
                cmd.cordic_step = 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/wdvm_datapath.sv @@
// Datapath: trig table, accumulators, CORDIC vectoring unit and result register.
module wdvm_datapath #(
    parameter int COUNT_BITS = 16,
    parameter int TRIG_BITS  = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  wdvm_pkg::dp_cmd_t                       cmd,
    output wdvm_pkg::dp_status_t                    status,
    input  logic                                    command,
    input  logic [wdvm_pkg::DIR_BITS-1:0]           direction,
    output logic                                    accepted,
    output logic                                    has_samples,
    output logic [wdvm_pkg::DIR_BITS-1:0]           current_direction,
    output logic [wdvm_pkg::DIR_BITS-1:0]           average_direction,
    output logic [wdvm_pkg::OUT_COUNT_BITS-1:0]     sample_count
);

    localparam int ACC_BITS = COUNT_BITS + TRIG_BITS + 1;
    localparam int XY_BITS  = ACC_BITS + 2;
    localparam int CW_BITS  = (COUNT_BITS > wdvm_pkg::OUT_COUNT_BITS) ?
                              COUNT_BITS : wdvm_pkg::OUT_COUNT_BITS;
    localparam logic [wdvm_pkg::DIR_BITS-1:0] DEG_MAX = wdvm_pkg::DIR_LIMIT - 1'b1;

    localparam wdvm_pkg::trig_rom_t COS_ROM = wdvm_pkg::build_trig_rom(TRIG_BITS, 1'b0);
    localparam wdvm_pkg::trig_rom_t SIN_ROM = wdvm_pkg::build_trig_rom(TRIG_BITS, 1'b1);

    // Item held while it is worked on
    logic                          clear_reg;
    logic [wdvm_pkg::DIR_BITS-1:0] dir_reg;
    logic                          dir_ok_reg;
    logic signed [TRIG_BITS-1:0]   cos_rd_reg;
    logic signed [TRIG_BITS-1:0]   sin_rd_reg;
    logic [wdvm_pkg::DIR_BITS-1:0] rom_addr;
    logic                          dir_ok;

    // Accumulated state
    logic [COUNT_BITS-1:0]         count_reg;
    logic [COUNT_BITS-1:0]         count_next;
    logic [wdvm_pkg::DIR_BITS-1:0] last_angle_reg;
    logic [wdvm_pkg::DIR_BITS-1:0] last_angle_next;
    logic signed [ACC_BITS-1:0]    cos_sum_reg;
    logic signed [ACC_BITS-1:0]    cos_sum_next;
    logic signed [ACC_BITS-1:0]    sin_sum_reg;
    logic signed [ACC_BITS-1:0]    sin_sum_next;
    logic                          item_ok_reg;
    logic                          item_ok_next;

    // CORDIC unit
    logic signed [XY_BITS-1:0]     x_reg;
    logic signed [XY_BITS-1:0]     x_next;
    logic signed [XY_BITS-1:0]     y_reg;
    logic signed [XY_BITS-1:0]     y_next;
    wdvm_pkg::angle_t              z_reg;
    wdvm_pkg::angle_t              z_next;
    logic signed [XY_BITS-1:0]     dx;
    logic signed [XY_BITS-1:0]     dy;
    logic signed [XY_BITS-1:0]     cos_ext;
    logic signed [XY_BITS-1:0]     sin_ext;
    wdvm_pkg::angle_t              step_ang;

    // Final angle
    wdvm_pkg::angle_t              z_wrap;
    logic [wdvm_pkg::DIR_BITS-1:0] deg;
    logic [wdvm_pkg::DIR_BITS-1:0] mean_deg;
    logic [CW_BITS-1:0]            count_wide;

    // Table read on the item's own cycle; invalid directions read entry zero.
    assign dir_ok   = (direction < wdvm_pkg::DIR_LIMIT);
    assign rom_addr = dir_ok ? direction : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            clear_reg  <= command;
            dir_reg    <= direction;
            dir_ok_reg <= dir_ok;
            cos_rd_reg <= COS_ROM[rom_addr][TRIG_BITS-1:0];
            sin_rd_reg <= SIN_ROM[rom_addr][TRIG_BITS-1:0];
        end
    end

    // Sample update: clear, add, or leave unchanged when refused.
    always_comb
    begin
        count_next      = count_reg;
        last_angle_next = last_angle_reg;
        cos_sum_next    = cos_sum_reg;
        sin_sum_next    = sin_sum_reg;
        item_ok_next    = 1'b0;
        if (clear_reg)
        begin
            count_next      = '0;
            last_angle_next = '0;
            cos_sum_next    = '0;
            sin_sum_next    = '0;
        end
        else if (dir_ok_reg && (count_reg != {COUNT_BITS{1'b1}}))
        begin
            count_next      = count_reg + 1'b1;
            last_angle_next = dir_reg;
            cos_sum_next    = cos_sum_reg + ACC_BITS'(cos_rd_reg);
            sin_sum_next    = sin_sum_reg + ACC_BITS'(sin_rd_reg);
            item_ok_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            last_angle_reg <= '0;
            cos_sum_reg    <= '0;
            sin_sum_reg    <= '0;
            item_ok_reg    <= 1'b0;
        end
        else if (cmd.accumulate)
        begin
            count_reg      <= count_next;
            last_angle_reg <= last_angle_next;
            cos_sum_reg    <= cos_sum_next;
            sin_sum_reg    <= sin_sum_next;
            item_ok_reg    <= item_ok_next;
        end
    end

    // No samples, or a zero vector, gives a mean of zero without the CORDIC.
    assign status.mean_trivial = (count_reg == '0) ||
                                 ((cos_sum_reg == '0) && (sin_sum_reg == '0));

    // CORDIC vectoring: start in the right half plane, one step per cycle.
    assign cos_ext  = XY_BITS'(cos_sum_reg);
    assign sin_ext  = XY_BITS'(sin_sum_reg);
    assign dx       = y_reg >>> cmd.step_idx;
    assign dy       = x_reg >>> cmd.step_idx;
    assign step_ang = wdvm_pkg::STEP_ANGLE[cmd.step_idx];

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (cmd.cordic_init)
        begin
            // The rounding guard is folded into the start angle.
            if (cos_sum_reg[ACC_BITS-1])
            begin
                x_next = -cos_ext;
                y_next = -sin_ext;
                z_next = wdvm_pkg::HALF_TURN + wdvm_pkg::ANGLE_GUARD;
            end
            else
            begin
                x_next = cos_ext;
                y_next = sin_ext;
                z_next = wdvm_pkg::ANGLE_GUARD;
            end
        end
        else if (cmd.cordic_step)
        begin
            if (!y_reg[XY_BITS-1])
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + step_ang;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - step_ang;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    // Wrap the angle once into a full turn and take whole degrees.
    always_comb
    begin
        if (z_reg < 0)
        begin
            z_wrap = z_reg + wdvm_pkg::FULL_TURN;
        end
        else if (z_reg >= wdvm_pkg::FULL_TURN)
        begin
            z_wrap = z_reg - wdvm_pkg::FULL_TURN;
        end
        else
        begin
            z_wrap = z_reg;
        end
        if (z_wrap < 0)
        begin
            z_wrap = '0;
        end
        deg      = z_wrap[wdvm_pkg::DEG_FRAC +: wdvm_pkg::DIR_BITS];
        mean_deg = (deg > DEG_MAX) ? DEG_MAX : deg;
        if (status.mean_trivial)
        begin
            mean_deg = '0;
        end
    end

    assign count_wide = CW_BITS'(count_reg);

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            accepted          <= item_ok_reg;
            has_samples       <= (count_reg != '0);
            current_direction <= last_angle_reg;
            average_direction <= mean_deg;
            sample_count      <= count_wide[wdvm_pkg::OUT_COUNT_BITS-1:0];
        end
    end

endmodule

@@ hw/rtl/wind_direction_vector_mean.sv @@
// Top level of the wind direction vector mean block.
//
//  channel  direction  handshake            payload
//  input    in         in_valid / in_ready  command, direction
//  result   out        out_valid/out_ready  accepted, has_samples, current_direction,
//                                           average_direction, sample_count
//
// An item holds the block from its accepting cycle through the accumulate state, the CORDIC
// init state, the ARCTAN_STEPS vectoring steps at one step per cycle and the finish state;
// its result is registered as the finish state is left. A clear item, or one that leaves no
// samples or a zero vector, skips the CORDIC steps. No new item is taken until this is done.
// A stalled result stays in the output register while the next item is worked on; that item
// then waits in its last step until the register frees. rst_n clears the control state and the accumulators at once.
`include "wind_direction_vector_mean_macros.svh"

module wind_direction_vector_mean #(
    parameter int COUNT_BITS   = 16,
    parameter int TRIG_BITS    = 16,
    parameter int ARCTAN_STEPS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [wdvm_pkg::DIR_BITS-1:0]       direction,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                accepted,
    output logic                                has_samples,
    output logic [wdvm_pkg::DIR_BITS-1:0]       current_direction,
    output logic [wdvm_pkg::DIR_BITS-1:0]       average_direction,
    output logic [wdvm_pkg::OUT_COUNT_BITS-1:0] sample_count
);

    wdvm_pkg::dp_cmd_t    cmd;
    wdvm_pkg::dp_status_t status;

    // Sequencer.
    wdvm_ctrl #(
        .ARCTAN_STEPS (ARCTAN_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and storage.
    wdvm_datapath #(
        .COUNT_BITS (COUNT_BITS),
        .TRIG_BITS  (TRIG_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .command           (command),
        .direction         (direction),
        .accepted          (accepted),
        .has_samples       (has_samples),
        .current_direction (current_direction),
        .average_direction (average_direction),
        .sample_count      (sample_count)
    );

    // Checks on the sequencing and on the result fields.
    `WDVM_ASSERT_NXT(a_one_item_in_work, in_valid && in_ready, !in_ready,
        "a second item was taken while one is in work")
    `WDVM_ASSERT_IMP(a_mean_in_range, out_valid, average_direction < wdvm_pkg::DIR_LIMIT,
        "mean direction outside one full turn")
    `WDVM_ASSERT_IMP(a_empty_is_zero, out_valid && !has_samples,
        (sample_count == '0) && (current_direction == '0) && (average_direction == '0),
        "empty state reported non-zero fields")
    `WDVM_ASSERT_IMP(a_accept_has_samples, out_valid && accepted, has_samples,
        "accepted sample but no samples held")

endmodule
